[hdl/rpft_pkg.sv]
// ----------------------------------------------------------------------------
// rpft_pkg
// Shared types and constants for the RSSI peak frequency tracker.
// ----------------------------------------------------------------------------
package rpft_pkg;

	localparam int FREQ_W = 30;
	localparam int FRAC_W = 8;
	localparam int FILT_W = FREQ_W + FRAC_W;
	localparam int DIFF_W = FILT_W + 1;
	localparam int GAIN_W = 8;
	localparam int PROD_W = DIFF_W + GAIN_W + 1;
	localparam int RSSI_W = 9;
	localparam int HOLD_W = 5;

	localparam logic signed [DIFF_W-1:0] JUMP_LIMIT = DIFF_W'(64'd500000 << FRAC_W);
	localparam logic [GAIN_W-1:0] GAIN_FAST = GAIN_W'(230);
	localparam logic [GAIN_W-1:0] GAIN_SLOW = GAIN_W'(8);
	localparam logic signed [PROD_W-1:0] GAIN_ROUND = PROD_W'(128);

	localparam logic [HOLD_W-1:0] HOLD_START        = HOLD_W'(20);
	localparam logic [HOLD_W-1:0] HOLD_RELEASE      = HOLD_W'(18);
	localparam logic [HOLD_W-1:0] HOLD_COARSE_LIMIT = HOLD_W'(10);

	localparam logic signed [RSSI_W-1:0] PEAK_FLOOR    = -RSSI_W'(254);
	localparam logic signed [RSSI_W-1:0] TRIGGER_RESET = -RSSI_W'(194);

	typedef enum logic [1:0] {
		MODE_COARSE    = 2'd0,
		MODE_FINE      = 2'd1,
		MODE_SWEEP_END = 2'd2,
		MODE_UNUSED    = 2'd3
	} mode_t;

	typedef logic [FREQ_W-1:0]        freq_t;
	typedef logic [FILT_W-1:0]        filt_t;
	typedef logic signed [RSSI_W-1:0] rssi_t;

endpackage

[hdl/rpft_ema.sv]
// ----------------------------------------------------------------------------
// rpft_ema
// Adaptive exponential moving average of the reported peak frequency.
// Gain 230/256 on a large jump, 8/256 otherwise; a zero filter is seeded.
// ----------------------------------------------------------------------------
module rpft_ema import rpft_pkg::*; (
	input  filt_t filter,
	input  freq_t sample,
	output filt_t filter_next,
	output freq_t freq_out
);

	filt_t                    sample_ext;
	logic signed [DIFF_W-1:0] diff;
	logic                     fast;
	logic [GAIN_W-1:0]        gain;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] step;
	logic signed [PROD_W-1:0] sum;

	always_comb begin
		sample_ext = {sample, FRAC_W'(0)};
		diff       = $signed({1'b0, sample_ext}) - $signed({1'b0, filter});
		fast       = (diff > JUMP_LIMIT) || (diff < -JUMP_LIMIT);
		gain       = fast ? GAIN_FAST : GAIN_SLOW;
		prod       = PROD_W'(diff) * $signed(PROD_W'({1'b0, gain}));
		step       = (prod + GAIN_ROUND) >>> GAIN_W;
		sum        = $signed(PROD_W'({1'b0, filter})) + step;
		if (filter == '0) begin
			filter_next = sample_ext;
			freq_out    = sample;
		end else begin
			filter_next = sum[FILT_W-1:0];
			freq_out    = sum[FILT_W-1:FRAC_W];
		end
	end

endmodule

[hdl/rssi_peak_frequency_tracker_unit.sv]
// ----------------------------------------------------------------------------
// rssi_peak_frequency_tracker_unit
// Coarse and fine RSSI peak tracking with hold logic and a filtered report.
// ----------------------------------------------------------------------------
// One word in, one word out. A word is registered on entry, then the peak,
// hold and filter update is done into the output register. A new word is
// taken every cycle unless out_stall holds the output; the single state
// update path (peaks, hold counter, filter) sets that rate. Every word
// yields a result; report_valid marks the sweep ends that carry a report.
module rssi_peak_frequency_tracker_unit import rpft_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  rssi_t        cfg_wr_data,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [1:0]   mode,
	input  freq_t        frequency,
	input  rssi_t        rssi,
	output logic         out_valid,
	input  logic         out_stall,
	output logic         report_valid,
	output freq_t        report_frequency,
	output rssi_t        report_rssi,
	output logic         report_active,
	output freq_t        coarse_peak_frequency,
	output logic         coarse_triggered
);

	// input stage
	logic  valid_s1;
	mode_t mode_s1;
	freq_t freq_s1;
	rssi_t rssi_s1;

	// tracker state
	rssi_t             trig_q;
	rssi_t             coarse_rssi_q, fine_rssi_q, held_rssi_q;
	freq_t             coarse_freq_q, fine_freq_q, held_freq_q;
	logic [HOLD_W-1:0] hold_q;
	filt_t             filter_q;

	// result register
	logic  out_valid_q, rep_valid_q, rep_active_q, coarse_trig_q;
	freq_t rep_freq_q, coarse_out_q;
	rssi_t rep_rssi_q;

	logic in_accept, advance;

	rssi_t             coarse_rssi_d, fine_rssi_d, held_rssi_d, rep_rssi_d;
	freq_t             coarse_freq_d, fine_freq_d, held_freq_d, rep_freq_d;
	logic [HOLD_W-1:0] hold_d, hold_dec;
	filt_t             filter_d, ema_filter;
	freq_t             ema_sample, ema_freq;
	logic              rep_valid_d, rep_active_d, fine_hit, coarse_hit;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	assign fine_hit   = fine_rssi_q > trig_q;
	assign coarse_hit = (coarse_rssi_q > trig_q) && (hold_q < HOLD_COARSE_LIMIT);
	assign ema_sample = fine_hit ? fine_freq_q : coarse_freq_q;
	assign hold_dec   = hold_q - HOLD_W'(1);

	rpft_ema u_ema (
		.filter      (filter_q),
		.sample      (ema_sample),
		.filter_next (ema_filter),
		.freq_out    (ema_freq)
	);

	always_comb begin
		coarse_rssi_d = coarse_rssi_q;
		coarse_freq_d = coarse_freq_q;
		fine_rssi_d   = fine_rssi_q;
		fine_freq_d   = fine_freq_q;
		held_rssi_d   = held_rssi_q;
		held_freq_d   = held_freq_q;
		hold_d        = hold_q;
		filter_d      = filter_q;
		rep_valid_d   = 1'b0;
		rep_active_d  = 1'b0;
		rep_freq_d    = '0;
		rep_rssi_d    = '0;
		case (mode_s1)
			MODE_COARSE: begin
				if (rssi_s1 > coarse_rssi_q) begin
					coarse_rssi_d = rssi_s1;
					coarse_freq_d = freq_s1;
				end
			end
			MODE_FINE: begin
				if (rssi_s1 > fine_rssi_q) begin
					fine_rssi_d = rssi_s1;
					fine_freq_d = freq_s1;
				end
			end
			MODE_SWEEP_END: begin
				if (fine_hit || coarse_hit) begin
					hold_d       = HOLD_START;
					held_rssi_d  = fine_hit ? fine_rssi_q : coarse_rssi_q;
					held_freq_d  = ema_sample;
					filter_d     = ema_filter;
					rep_valid_d  = 1'b1;
					rep_active_d = 1'b1;
					rep_freq_d   = ema_freq;
					rep_rssi_d   = fine_hit ? fine_rssi_q : coarse_rssi_q;
				end else if (hold_q != '0) begin
					hold_d = hold_dec;
					if (hold_dec == HOLD_RELEASE) begin
						rep_valid_d = 1'b1;
						rep_freq_d  = held_freq_q;
						rep_rssi_d  = held_rssi_q;
					end
				end else begin
					filter_d    = '0;
					rep_valid_d = 1'b1;
				end
				coarse_rssi_d = PEAK_FLOOR;
				coarse_freq_d = '0;
				fine_rssi_d   = PEAK_FLOOR;
				fine_freq_d   = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1 <= mode_t'(mode);
			freq_s1 <= frequency;
			rssi_s1 <= rssi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q <= TRIGGER_RESET;
		end else if (cfg_wr_en) begin
			trig_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coarse_rssi_q <= PEAK_FLOOR;
			coarse_freq_q <= '0;
			fine_rssi_q   <= PEAK_FLOOR;
			fine_freq_q   <= '0;
			held_rssi_q   <= '0;
			held_freq_q   <= '0;
			hold_q        <= '0;
			filter_q      <= '0;
		end else if (advance) begin
			coarse_rssi_q <= coarse_rssi_d;
			coarse_freq_q <= coarse_freq_d;
			fine_rssi_q   <= fine_rssi_d;
			fine_freq_q   <= fine_freq_d;
			held_rssi_q   <= held_rssi_d;
			held_freq_q   <= held_freq_d;
			hold_q        <= hold_d;
			filter_q      <= filter_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			rep_valid_q   <= rep_valid_d;
			rep_active_q  <= rep_active_d;
			rep_freq_q    <= rep_freq_d;
			rep_rssi_q    <= rep_rssi_d;
			coarse_out_q  <= coarse_freq_d;
			coarse_trig_q <= coarse_rssi_d > trig_q;
		end
	end

	assign out_valid             = out_valid_q;
	assign report_valid          = rep_valid_q;
	assign report_frequency      = rep_freq_q;
	assign report_rssi           = rep_rssi_q;
	assign report_active         = rep_active_q;
	assign coarse_peak_frequency = coarse_out_q;
	assign coarse_triggered      = coarse_trig_q;

`ifndef ASSERT_OFF
	a_hold_range: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q <= HOLD_START)
		else $error("hold counter beyond start value");

	a_active_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rep_active_q |-> rep_valid_q && (rep_rssi_q > trig_q))
		else $error("active report without valid trigger");

	a_peaks_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (mode_s1 == MODE_SWEEP_END) |=>
		(coarse_rssi_q == PEAK_FLOOR) && (fine_rssi_q == PEAK_FLOOR))
		else $error("peaks not cleared after sweep end");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("stall with empty input stage");
`endif

endmodule
